[rtl/running_median_two_heaps_defines.svh]
// Assertion macros for the top RTL file of the running median block.
`ifndef RUNNING_MEDIAN_TWO_HEAPS_DEFINES_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_DEFINES_SVH

`ifndef SYNTHESIS
`define RMH_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("running median assertion failed");
`define RMH_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("running median assertion failed");
`else
`define RMH_ASSERT_IMP(lbl, pre, post)
`define RMH_ASSERT_NXT(lbl, pre, post)
`endif

`endif

[rtl/rmh_pkg.sv]
`timescale 1ns / 1ps

package rmh_pkg;

  localparam int CAPACITY   = 1024;
  localparam int HEAP_DEPTH = CAPACITY / 2 + 2;
  localparam int IDX_W      = $clog2(HEAP_DEPTH);
  localparam int SIZE_W     = $clog2(HEAP_DEPTH + 1);
  localparam int COUNT_W    = 11;
  localparam int DATA_W     = 32;

  typedef enum logic [2:0] {
    H_IDLE, H_UP, H_UP_CMP, H_DN_LAST, H_DN, H_DN_L, H_DN_R
  } heap_state_t;

  typedef enum logic [3:0] {
    T_IDLE, T_INS, T_INS_WAIT, T_CHECK, T_POP, T_POP_WAIT,
    T_PUSH, T_PUSH_WAIT, T_BAL, T_EMIT
  } top_state_t;

  typedef struct packed {
    logic                     start;
    logic                     pop;
    logic signed [DATA_W-1:0] value;
  } heap_cmd_t;

  typedef struct packed {
    logic                     busy;
    logic signed [DATA_W-1:0] top;
    logic [SIZE_W-1:0]        size;
  } heap_stat_t;

  // True if a belongs above b in the heap.
  function automatic logic heap_before(input logic signed [DATA_W-1:0] a,
                                       input logic signed [DATA_W-1:0] b,
                                       input logic is_max);
    heap_before = is_max ? (a > b) : (a < b);
  endfunction

endpackage

[rtl/rmh_heap.sv]
`timescale 1ns / 1ps

module rmh_heap import rmh_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       max_heap,
  input  heap_cmd_t  cmd,
  output heap_stat_t stat
);

  logic signed [DATA_W-1:0] mem [HEAP_DEPTH];
  logic signed [DATA_W-1:0] rdata;
  logic signed [DATA_W-1:0] top;
  logic signed [DATA_W-1:0] val;
  logic signed [DATA_W-1:0] last;
  logic signed [DATA_W-1:0] lval;
  logic [SIZE_W-1:0]        size;
  logic [IDX_W-1:0]         idx;
  heap_state_t              state, state_next;

  logic [IDX_W-1:0]         rd_addr;
  logic                     we;
  logic [IDX_W-1:0]         waddr;
  logic signed [DATA_W-1:0] wdata;
  logic [IDX_W-1:0]         parent;
  logic [IDX_W:0]           lidx, ridx;
  logic                     l_ok, r_ok, take_l, take_r;
  logic signed [DATA_W-1:0] cand;

  function automatic logic [IDX_W-2:0] idx_dec_hi(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] d;
    d = i - IDX_W'(1);
    idx_dec_hi = d[IDX_W-1:1];
  endfunction

  assign parent = {1'b0, idx_dec_hi(idx)};

  assign lidx   = {idx, 1'b1};
  assign ridx   = lidx + (IDX_W+1)'(1);
  assign l_ok   = lidx < (IDX_W+1)'(size);
  assign r_ok   = ridx < (IDX_W+1)'(size);
  assign take_l = l_ok && heap_before(lval, last, max_heap);
  assign cand   = take_l ? lval : last;
  assign take_r = r_ok && heap_before(rdata, cand, max_heap);

  always_comb begin
    state_next = state;
    unique case (state)
      H_IDLE:    if (cmd.start) state_next = cmd.pop ? H_DN_LAST : H_UP;
      H_UP:      state_next = (idx == '0) ? H_IDLE : H_UP_CMP;
      H_UP_CMP:  state_next = heap_before(val, rdata, max_heap) ? H_UP : H_IDLE;
      H_DN_LAST: state_next = H_DN;
      H_DN:      state_next = l_ok ? H_DN_L : H_IDLE;
      H_DN_L:    state_next = H_DN_R;
      H_DN_R:    state_next = (take_l || take_r) ? H_DN : H_IDLE;
      default:   state_next = H_IDLE;
    endcase
  end

  always_comb begin
    rd_addr = idx;
    we      = 1'b0;
    waddr   = idx;
    wdata   = val;
    unique case (state)
      H_IDLE:    rd_addr = IDX_W'(size - SIZE_W'(1));
      H_UP: begin
        rd_addr = parent;
        we      = (idx == '0);
      end
      H_UP_CMP: begin
        we    = 1'b1;
        wdata = heap_before(val, rdata, max_heap) ? rdata : val;
      end
      H_DN_LAST: ;
      H_DN: begin
        rd_addr = lidx[IDX_W-1:0];
        we      = !l_ok;
        wdata   = last;
      end
      H_DN_L:    rd_addr = ridx[IDX_W-1:0];
      H_DN_R: begin
        we    = 1'b1;
        wdata = take_r ? rdata : cand;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    rdata <= mem[rd_addr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
      size  <= '0;
    end else begin
      state <= state_next;
      if (state == H_IDLE && cmd.start) begin
        size <= cmd.pop ? size - SIZE_W'(1) : size + SIZE_W'(1);
      end
    end
    if (we && waddr == '0) begin
      top <= wdata;
    end
    unique case (state)
      H_IDLE: begin
        val <= cmd.value;
        idx <= IDX_W'(size);
      end
      H_UP_CMP:  if (heap_before(val, rdata, max_heap)) idx <= parent;
      H_DN_LAST: begin
        last <= rdata;
        idx  <= '0;
      end
      H_DN_L:    lval <= rdata;
      H_DN_R:    idx <= take_r ? ridx[IDX_W-1:0] : lidx[IDX_W-1:0];
      default: ;
    endcase
  end

  assign stat.busy = (state != H_IDLE);
  assign stat.top  = top;
  assign stat.size = size;

endmodule

[rtl/running_median_two_heaps.sv]
`timescale 1ns / 1ps
// Running median over a stream of signed 32-bit samples.
// Input channel: sample_valid / sample_stall / sample_value. An item is taken
// at a clock edge where sample_valid is high and sample_stall is low.
// Output channel: result_valid / result_stall with twice_median (33-bit signed),
// stored_count and dropped_full. Every input item yields exactly one result item.
// The lower half of the values sits in a max-heap and the upper half in a
// min-heap, each in its own synchronous RAM with one read and one write port.
// An item costs one push plus up to two pop/push moves; a sift level runs through
// H_UP and H_UP_CMP on a push and H_DN, H_DN_L and H_DN_R on a pop, as the RAM
// gives one read per cycle with registered read data. A dropped item goes from
// T_IDLE straight to T_EMIT without touching the heaps.
// One item is worked on at a time; sample_stall is high while it is in flight.
// The finished result sits in an output register, so a new item can be taken
// while the previous result still waits; if the receiver stalls, the next
// result is held back until the register is free.
// Reset (rst, synchronous) empties both heaps; no RAM clearing pass is needed.
// Once CAPACITY values are held, further items are dropped with dropped_full set.
`include "running_median_two_heaps_defines.svh"

module running_median_two_heaps import rmh_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      sample_valid,
  output logic                      sample_stall,
  input  logic signed [DATA_W-1:0]  sample_value,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic signed [DATA_W:0]    twice_median,
  output logic [COUNT_W-1:0]        stored_count,
  output logic                      dropped_full
);

  top_state_t               state, state_next;
  heap_cmd_t                lo_cmd, hi_cmd;
  heap_stat_t               lo_stat, hi_stat;
  logic signed [DATA_W-1:0] sample;
  logic signed [DATA_W-1:0] moving;
  logic                     to_upper;   // direction of the current move
  logic                     balancing;  // set once the compare move is over
  logic                     dropped;

  logic [COUNT_W-1:0]       total;
  logic [COUNT_W-1:0]       lsz, usz;
  logic                     full;
  logic                     need_cross, up_heavy, lo_heavy;
  logic                     src_busy, dst_busy, emit_ok;
  logic signed [DATA_W:0]   median2;

  assign lsz        = COUNT_W'(lo_stat.size);
  assign usz        = COUNT_W'(hi_stat.size);
  assign total      = lsz + usz;
  assign full       = total >= COUNT_W'(CAPACITY);
  assign need_cross = (hi_stat.size != '0) && (lo_stat.top > hi_stat.top);
  assign up_heavy   = usz > lsz + COUNT_W'(1);
  assign lo_heavy   = lsz > usz + COUNT_W'(1);
  assign src_busy   = to_upper ? lo_stat.busy : hi_stat.busy;
  assign dst_busy   = to_upper ? hi_stat.busy : lo_stat.busy;
  assign emit_ok    = !result_valid || !result_stall;

  // Twice the median: the larger heap's top doubled, the sum of both tops, or zero when both are empty.
  always_comb begin
    priority if (lsz < usz) begin
      median2 = {hi_stat.top, 1'b0};
    end else if (lsz > usz) begin
      median2 = {lo_stat.top, 1'b0};
    end else if (lsz == '0) begin
      median2 = '0;
    end else begin
      median2 = (DATA_W+1)'(lo_stat.top) + (DATA_W+1)'(hi_stat.top);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      T_IDLE:      if (sample_valid) state_next = full ? T_EMIT : T_INS;
      T_INS:       state_next = T_INS_WAIT;
      T_INS_WAIT:  if (!lo_stat.busy) state_next = T_CHECK;
      T_CHECK:     state_next = need_cross ? T_POP : T_BAL;
      T_POP:       state_next = T_POP_WAIT;
      T_POP_WAIT:  if (!src_busy) state_next = T_PUSH;
      T_PUSH:      state_next = T_PUSH_WAIT;
      T_PUSH_WAIT: if (!dst_busy) state_next = balancing ? T_EMIT : T_BAL;
      T_BAL:       state_next = (up_heavy || lo_heavy) ? T_POP : T_EMIT;
      T_EMIT:      if (emit_ok) state_next = T_IDLE;
      default:     state_next = T_IDLE;
    endcase
  end

  always_comb begin
    lo_cmd       = '{start: 1'b0, pop: 1'b0, value: sample};
    hi_cmd       = '{start: 1'b0, pop: 1'b0, value: moving};
    sample_stall = (state != T_IDLE);
    unique case (state)
      T_INS: lo_cmd.start = 1'b1;
      T_POP: begin
        if (to_upper) begin
          lo_cmd = '{start: 1'b1, pop: 1'b1, value: sample};
        end else begin
          hi_cmd = '{start: 1'b1, pop: 1'b1, value: moving};
        end
      end
      T_PUSH: begin
        if (to_upper) begin
          hi_cmd = '{start: 1'b1, pop: 1'b0, value: moving};
        end else begin
          lo_cmd = '{start: 1'b1, pop: 1'b0, value: moving};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= T_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == T_EMIT && emit_ok) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
    unique case (state)
      T_IDLE: begin
        sample    <= sample_value;
        dropped   <= full;
        balancing <= 1'b0;
      end
      T_CHECK: to_upper <= 1'b1;
      T_POP:   moving <= to_upper ? lo_stat.top : hi_stat.top;
      T_BAL: begin
        balancing <= 1'b1;
        to_upper  <= !up_heavy;
      end
      T_EMIT: begin
        if (emit_ok) begin
          twice_median <= median2;
          stored_count <= total;
          dropped_full <= dropped;
        end
      end
      default: ;
    endcase
  end

  rmh_heap u_lower (
    .clk      (clk),
    .rst      (rst),
    .max_heap (1'b1),
    .cmd      (lo_cmd),
    .stat     (lo_stat)
  );

  rmh_heap u_upper (
    .clk      (clk),
    .rst      (rst),
    .max_heap (1'b0),
    .cmd      (hi_cmd),
    .stat     (hi_stat)
  );

  `RMH_ASSERT_IMP(a_balanced_idle, state == T_IDLE, !up_heavy && !lo_heavy)
  `RMH_ASSERT_IMP(a_heaps_quiet_idle, state == T_IDLE, !lo_stat.busy && !hi_stat.busy)
  `RMH_ASSERT_IMP(a_count_range, state == T_IDLE, total <= COUNT_W'(CAPACITY))
  `RMH_ASSERT_NXT(a_busy_after_take, sample_valid && !sample_stall, sample_stall)

endmodule

[tb/sv/running_median_two_heaps_tb.sv]
`timescale 1ns / 1ps

module running_median_two_heaps_tb;
  import rmh_pkg::*;

  localparam int NUM_RANDOM = 782;

  // One expected result item: twice the median, the stored count and the drop flag.
  typedef struct {
    logic signed [DATA_W:0] twice_med;
    logic [COUNT_W-1:0]     count;
    logic                   dropped;
  } median_result_t;

  // The scoreboard keeps every stored sample in a sorted queue. Any split into a lower
  // and an upper half with sizes within one of each other gives the same median, so
  // the sorted list predicts the result without copying the heap mechanics.
  class median_scoreboard;
    longint         sorted_samples[$];
    median_result_t pending[$];
    int             errors;

    task report(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
    endtask

    function void note_sample(logic signed [DATA_W-1:0] value);
      median_result_t r;
      longint         v;
      int             n;
      int             pos;
      v = value;
      n = sorted_samples.size();
      r.dropped = (n >= CAPACITY);
      if (!r.dropped) begin
        // Insert after any equal values; order among equals does not matter.
        pos = 0;
        while (pos < n && sorted_samples[pos] <= v) pos++;
        sorted_samples.insert(pos, v);
        n++;
      end
      if (n[0])
        r.twice_med = 33'(2 * sorted_samples[n / 2]);
      else
        r.twice_med = 33'(sorted_samples[n / 2 - 1] + sorted_samples[n / 2]);
      r.count = COUNT_W'(n);
      pending.push_back(r);
    endfunction

    task check_result(logic signed [DATA_W:0] tm, logic [COUNT_W-1:0] cnt, logic df);
      median_result_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result twice_median=%0d count=%0d", tm, cnt));
      end else begin
        e = pending.pop_front();
        if (tm !== e.twice_med)
          report($sformatf("twice_median got %0d want %0d", tm, e.twice_med));
        if (cnt !== e.count)
          report($sformatf("stored_count got %0d want %0d", cnt, e.count));
        if (df !== e.dropped)
          report($sformatf("dropped_full got %0b want %0b", df, e.dropped));
      end
    endtask
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     sample_valid = 1'b0;
  logic                     sample_stall;
  logic signed [DATA_W-1:0] sample_value = '0;
  logic                     result_valid;
  logic                     result_stall = 1'b0;
  logic signed [DATA_W:0]   twice_median;
  logic [COUNT_W-1:0]       stored_count;
  logic                     dropped_full;

  // While this is set, neither side idles, so the block runs back to back.
  logic steady = 1'b0;

  median_scoreboard sb = new();

  running_median_two_heaps u_top (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_value (sample_value),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .twice_median (twice_median),
    .stored_count (stored_count),
    .dropped_full (dropped_full)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver stalls at random, with a chance of 12 in a hundred, except in the steady window.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      result_stall <= !steady && ($urandom_range(99) < 12);
    end
  end

  // Results are sampled at the clock edge, so the values seen are the ones the
  // block held before that edge.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      sb.check_result(twice_median, stored_count, dropped_full);
  end

  // Offers one sample and holds it until the block takes it. Random idle cycles
  // come first so that gaps land on every phase of the block's work.
  task send_sample(logic signed [DATA_W-1:0] value);
    while (!steady && $urandom_range(99) < 12) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_value <= value;
    do @(posedge clk); while (sample_stall);
    sb.note_sample(value);
  endtask

  // Random sample: full range, a narrow band around zero that makes many
  // duplicates, one of the extremes, or a value within 16 bits of zero.
  function automatic logic signed [DATA_W-1:0] random_sample();
    case ($urandom_range(9))
      0, 1, 2, 3: random_sample = $urandom;
      4, 5, 6:    random_sample = $signed($urandom_range(40)) - 20;
      7:          random_sample = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default:    random_sample = $signed({$urandom_range(1) ? 16'hffff : 16'h0000,
                                           16'($urandom)});
    endcase
  endfunction

  initial begin
    int wait_cycles;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: the extremes, zero, neighbors of zero, ties and a sum that
    // needs the 33rd bit in both directions.
    send_sample(32'sh7fffffff);
    send_sample(32'sh7fffffff);
    send_sample(32'sh80000000);
    send_sample(32'sh80000000);
    send_sample(32'sh80000000);
    send_sample(32'sh80000000);
    send_sample(32'sh0);
    send_sample(-32'sd1);
    send_sample(32'sd1);
    send_sample(32'sd0);
    send_sample(32'sh55555555);
    send_sample(32'shaaaaaaaa);
    send_sample(32'sd5);
    send_sample(32'sd5);
    send_sample(32'sd5);
    send_sample(-32'sd7);
    send_sample(32'sh7ffffffe);
    send_sample(32'sh80000001);

    // Let every pending result drain before the random part starts.
    sample_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    @(posedge clk);

    // Random part; a stretch in the middle runs with no idling on either side.
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == 300) steady <= 1'b1;
      if (i == 450) steady <= 1'b0;
      send_sample(random_sample());
    end
    sample_valid <= 1'b0;

    wait_cycles = 0;
    while (sb.pending.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (200) @(posedge clk);

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("running_median_two_heaps regression: pass");
    end else begin
      $display("running_median_two_heaps regression: fail");
    end
    $finish;
  end

  // Generous limit: about 800 items, with idling on both sides, stay well below this.
  initial begin
    #20ms;
    $display("running_median_two_heaps regression: fail");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/rmh_pkg.sv
rtl/rmh_heap.sv
rtl/running_median_two_heaps.sv
tb/sv/running_median_two_heaps_tb.sv
